// ===== sv/dlt_tri_pkg.sv =====
package dlt_tri_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Accumulator, equation term and normal-matrix entry width
   localparam int ACC_W = 64;
   // Width of one hardware multiplier operand
   localparam int LIMB_W = 32;
   // Lane sum: holds a 64 x 64 product or a difference of two word products
   localparam int LANE_SUM_W = 2 * ACC_W + 2;
   // Cofactor of the 3x3 normal matrix
   localparam int COF_W = 2 * ACC_W + 1;
   // Determinant and numerators
   localparam int SOLVE_SUM_W = 3 * ACC_W + 2;

   typedef struct packed {
      logic clear;
      logic subtract;
   } mac_ctl_type;

   // Normal matrix entries 00, 01, 02, 11, 12, 22 and right-hand side
   typedef struct packed {
      logic [5:0][ACC_W-1:0] norm;
      logic [2:0][ACC_W-1:0] rhs;
   } acc_set_type;

endpackage

// ===== sv/dlt_tri_req_if.sv =====
interface dlt_tri_req_if #(
   parameter int WORD_BITS = dlt_tri_pkg::WORD_BITS_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  row_select;
   logic signed [WORD_BITS-1:0] coeff_0;
   logic signed [WORD_BITS-1:0] coeff_1;
   logic signed [WORD_BITS-1:0] coeff_2;
   logic signed [WORD_BITS-1:0] coeff_3;
   logic signed [WORD_BITS-1:0] image_x;
   logic signed [WORD_BITS-1:0] image_y;
   logic signed [WORD_BITS-1:0] image_w;
   logic                        last_item;

   modport source (
      output valid, row_select, coeff_0, coeff_1, coeff_2, coeff_3,
             image_x, image_y, image_w, last_item,
      input  ready
   );
   modport sink (
      input  valid, row_select, coeff_0, coeff_1, coeff_2, coeff_3,
             image_x, image_y, image_w, last_item,
      output ready
   );
endinterface

// ===== sv/dlt_tri_rsp_if.sv =====
interface dlt_tri_rsp_if #(
   parameter int WORD_BITS = dlt_tri_pkg::WORD_BITS_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] world_x;
   logic signed [WORD_BITS-1:0] world_y;
   logic signed [WORD_BITS-1:0] world_z;
   logic                        degenerate;

   modport source (
      output valid, world_x, world_y, world_z, degenerate,
      input  ready
   );
   modport sink (
      input  valid, world_x, world_y, world_z, degenerate,
      output ready
   );
endinterface

// ===== sv/dlt_tri_mac.sv =====
// Sequential signed multiply-accumulate: sum = (clear ? 0 : sum) +/- op_a * op_b,
// one 32 x 32 partial product at a time, formed in MULT and summed in ACCUM.
module dlt_tri_mac #(
   parameter int OP_W  = dlt_tri_pkg::ACC_W,
   parameter int SUM_W = dlt_tri_pkg::LANE_SUM_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  dlt_tri_pkg::mac_ctl_type ctl,
   input  logic signed [OP_W-1:0]   op_a,
   input  logic signed [OP_W-1:0]   op_b,
   output logic signed [SUM_W-1:0]  sum,
   output logic                     done
);
   localparam int LIMB_W = dlt_tri_pkg::LIMB_W;
   localparam int LIMBS  = (OP_W + LIMB_W - 1) / LIMB_W;
   localparam int PAD_W  = LIMBS * LIMB_W;
   localparam int PROD_W = 2 * PAD_W;
   localparam int IDX_W  = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int POS_W  = $clog2(2 * LIMBS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMBS - 1);

   typedef enum logic [1:0] {IDLE, MULT, ACCUM, FINISH} state_type;

   state_type               state_ff;
   logic [PAD_W-1:0]        mag_a_ff;
   logic [PAD_W-1:0]        mag_b_ff;
   logic [PAD_W-1:0]        ext_a;
   logic [PAD_W-1:0]        ext_b;
   logic [PAD_W-1:0]        abs_a;
   logic [PAD_W-1:0]        abs_b;
   logic                    neg_ff;
   logic                    clear_ff;
   logic                    done_ff;
   logic [IDX_W-1:0]        i_ff;
   logic [IDX_W-1:0]        j_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [2*LIMB_W-1:0]     pp_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] base;

   assign ext_a = PAD_W'(op_a);
   assign ext_b = PAD_W'(op_b);
   assign abs_a = op_a[OP_W-1] ? (PAD_W'(0) - ext_a) : ext_a;
   assign abs_b = op_b[OP_W-1] ? (PAD_W'(0) - ext_b) : ext_b;
   assign base  = clear_ff ? SUM_W'(0) : sum_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  mag_a_ff <= abs_a;
                  mag_b_ff <= abs_b;
                  neg_ff   <= op_a[OP_W-1] ^ op_b[OP_W-1] ^ ctl.subtract;
                  clear_ff <= ctl.clear;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  prod_ff  <= '0;
                  state_ff <= MULT;
               end
            end
            MULT: begin
               pp_ff    <= mag_a_ff[i_ff*LIMB_W +: LIMB_W] * mag_b_ff[j_ff*LIMB_W +: LIMB_W];
               pos_ff   <= POS_W'(i_ff) + POS_W'(j_ff);
               state_ff <= ACCUM;
            end
            ACCUM: begin
               prod_ff <= prod_ff + (PROD_W'(pp_ff) << (LIMB_W * pos_ff));
               state_ff <= MULT;
               if (j_ff == LAST_IDX) begin
                  j_ff <= '0;
                  if (i_ff == LAST_IDX) state_ff <= FINISH;
                  else i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            FINISH: begin
               sum_ff   <= neg_ff ? (base - SUM_W'(prod_ff)) : (base + SUM_W'(prod_ff));
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign sum  = sum_ff;
   assign done = done_ff;
endmodule

// ===== sv/dlt_tri_lane.sv =====
// One DLT equation: forms a0..a2 and b, then the nine normal-matrix and
// right-hand-side terms, on a shared multiply-accumulate unit.
module dlt_tri_lane #(
   parameter int WORD_BITS = dlt_tri_pkg::WORD_BITS_DEFAULT,
   parameter int FRAC_BITS = dlt_tri_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [3:0][WORD_BITS-1:0]     top_row,
   input  logic [3:0][WORD_BITS-1:0]     p2_row,
   input  logic [WORD_BITS-1:0]          image,
   input  logic [WORD_BITS-1:0]          scale_w,
   output dlt_tri_pkg::acc_set_type      terms,
   output logic                          done
);
   localparam int ACC_W = dlt_tri_pkg::ACC_W;
   localparam int SUM_W = dlt_tri_pkg::LANE_SUM_W;
   localparam logic [4:0] LAST_OP = 5'd16;

   typedef enum logic [1:0] {IDLE, ISSUE, WAIT} state_type;

   state_type                   state_ff;
   logic [4:0]                  op_ff;
   logic [3:0][WORD_BITS-1:0]   top_ff;
   logic [3:0][WORD_BITS-1:0]   p2_ff;
   logic [WORD_BITS-1:0]        img_ff;
   logic [WORD_BITS-1:0]        w_ff;
   logic [2:0][ACC_W-1:0]       a_ff;
   logic [ACC_W-1:0]            b_ff;
   dlt_tri_pkg::acc_set_type    terms_ff;
   logic                        done_ff;
   logic [1:0]                  eq_idx;
   logic [4:0]                  norm_idx;
   logic [4:0]                  rhs_idx;
   logic signed [ACC_W-1:0]     mul_a;
   logic signed [ACC_W-1:0]     mul_b;
   dlt_tri_pkg::mac_ctl_type    ctl;
   logic                        mac_start;
   logic signed [SUM_W-1:0]     mac_sum;
   logic signed [SUM_W-1:0]     sum_sh;
   logic                        mac_done;
   logic [ACC_W-1:0]            sat_term;

   function automatic logic signed [ACC_W-1:0] ext(input logic [WORD_BITS-1:0] v);
      return ACC_W'($signed(v));
   endfunction

   function automatic logic [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-ACC_W:0] hi;
      hi = v[SUM_W-1:ACC_W-1];
      if ((&hi) || !(|hi)) return v[ACC_W-1:0];
      else if (v[SUM_W-1]) return {1'b1, {(ACC_W-1){1'b0}}};
      else return {1'b0, {(ACC_W-1){1'b1}}};
   endfunction

   assign eq_idx    = op_ff[2:1];
   assign norm_idx  = op_ff - 5'd8;
   assign rhs_idx   = op_ff - 5'd14;
   assign mac_start = (state_ff == ISSUE);
   assign sum_sh    = mac_sum >>> FRAC_BITS;
   assign sat_term  = sat_acc(sum_sh);

   // Operand pick for each step: equation halves first, then products
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      ctl   = '0;
      if (op_ff < 5'd8) begin
         if (!op_ff[0]) begin
            ctl.clear = 1'b1;
            if (eq_idx == 2'd3) begin
               mul_a = ext(w_ff);
               mul_b = ext(top_ff[3]);
            end else begin
               mul_a = ext(img_ff);
               mul_b = ext(p2_ff[eq_idx]);
            end
         end else begin
            ctl.subtract = 1'b1;
            if (eq_idx == 2'd3) begin
               mul_a = ext(img_ff);
               mul_b = ext(p2_ff[3]);
            end else begin
               mul_a = ext(w_ff);
               mul_b = ext(top_ff[eq_idx]);
            end
         end
      end else begin
         ctl.clear = 1'b1;
         unique case (op_ff)
            5'd8:    begin mul_a = a_ff[0]; mul_b = a_ff[0]; end
            5'd9:    begin mul_a = a_ff[0]; mul_b = a_ff[1]; end
            5'd10:   begin mul_a = a_ff[0]; mul_b = a_ff[2]; end
            5'd11:   begin mul_a = a_ff[1]; mul_b = a_ff[1]; end
            5'd12:   begin mul_a = a_ff[1]; mul_b = a_ff[2]; end
            5'd13:   begin mul_a = a_ff[2]; mul_b = a_ff[2]; end
            5'd14:   begin mul_a = a_ff[0]; mul_b = b_ff; end
            5'd15:   begin mul_a = a_ff[1]; mul_b = b_ff; end
            5'd16:   begin mul_a = a_ff[2]; mul_b = b_ff; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   dlt_tri_mac #(.OP_W(ACC_W), .SUM_W(SUM_W)) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .ctl   (ctl),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .sum   (mac_sum),
      .done  (mac_done)
   );

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  top_ff   <= top_row;
                  p2_ff    <= p2_row;
                  img_ff   <= image;
                  w_ff     <= scale_w;
                  op_ff    <= '0;
                  state_ff <= ISSUE;
               end
            end
            ISSUE: state_ff <= WAIT;
            WAIT: begin
               if (mac_done) begin
                  if (op_ff < 5'd8) begin
                     if (op_ff[0]) begin
                        if (eq_idx == 2'd3) b_ff <= sat_term;
                        else a_ff[eq_idx] <= sat_term;
                     end
                  end else if (op_ff < 5'd14) begin
                     terms_ff.norm[norm_idx[2:0]] <= sat_term;
                  end else begin
                     terms_ff.rhs[rhs_idx[1:0]] <= sat_term;
                  end
                  if (op_ff == LAST_OP) begin
                     done_ff  <= 1'b1;
                     state_ff <= IDLE;
                  end else begin
                     op_ff    <= op_ff + 1'b1;
                     state_ff <= ISSUE;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign terms = terms_ff;
   assign done  = done_ff;
endmodule

// ===== sv/dlt_tri_merge.sv =====
// Saturating accumulators for the normal matrix and right-hand side.
module dlt_tri_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     add,
   input  dlt_tri_pkg::acc_set_type terms,
   output dlt_tri_pkg::acc_set_type acc
);
   localparam int ACC_W = dlt_tri_pkg::ACC_W;

   dlt_tri_pkg::acc_set_type acc_ff;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] t);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {t[ACC_W-1], t};
      if (s[ACC_W] == s[ACC_W-1]) return s[ACC_W-1:0];
      else if (s[ACC_W]) return {1'b1, {(ACC_W-1){1'b0}}};
      else return {1'b0, {(ACC_W-1){1'b1}}};
   endfunction

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         acc_ff <= '0;
      end else if (add) begin
         for (int k = 0; k < 6; k++) acc_ff.norm[k] <= sat_add(acc_ff.norm[k], terms.norm[k]);
         for (int k = 0; k < 3; k++) acc_ff.rhs[k] <= sat_add(acc_ff.rhs[k], terms.rhs[k]);
      end
   end

   assign acc = acc_ff;
endmodule

// ===== sv/dlt_tri_solve.sv =====
// 3x3 solve by cofactors on a shared multiply-accumulate unit; then, unless the
// determinant is zero, three restoring divisions, one quotient bit per cycle.
module dlt_tri_solve #(
   parameter int WORD_BITS = dlt_tri_pkg::WORD_BITS_DEFAULT,
   parameter int FRAC_BITS = dlt_tri_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  dlt_tri_pkg::acc_set_type acc,
   output logic [WORD_BITS-1:0]     world_x,
   output logic [WORD_BITS-1:0]     world_y,
   output logic [WORD_BITS-1:0]     world_z,
   output logic                     degenerate,
   output logic                     done
);
   localparam int ACC_W = dlt_tri_pkg::ACC_W;
   localparam int COF_W = dlt_tri_pkg::COF_W;
   localparam int SUM_W = dlt_tri_pkg::SOLVE_SUM_W;
   localparam int DVD_W = SUM_W + FRAC_BITS;
   localparam int REM_W = SUM_W + 1;
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [4:0] LAST_OP = 5'd23;

   typedef enum logic [2:0] {IDLE, ISSUE, WAIT, DIV_LOAD, DIV_STEP, DIV_STORE, FINISH}
      state_type;
   typedef enum logic [3:0] {
      S_N0, S_N1, S_N2, S_N3, S_N4, S_N5, S_R0, S_R1, S_R2,
      S_C0, S_C1, S_C2, S_C3, S_C4, S_C5
   } src_type;
   typedef struct packed {
      src_type src_a;
      src_type src_b;
      logic    clear;
   } op_type;

   state_type                  state_ff;
   logic [4:0]                 op_ff;
   logic [5:0][ACC_W-1:0]      n_ff;
   logic [2:0][ACC_W-1:0]      r_ff;
   logic [5:0][COF_W-1:0]      cof_ff;
   logic signed [SUM_W-1:0]    det_ff;
   logic [2:0][SUM_W-1:0]      num_ff;
   logic [1:0]                 idx_ff;
   logic [SUM_W-1:0]           dvs_ff;
   logic [DVD_W-1:0]           dvd_ff;
   logic [REM_W-1:0]           rem_ff;
   logic                       qneg_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [2:0][WORD_BITS-1:0]  res_ff;
   logic                       degenerate_ff;
   logic                       done_ff;
   op_type                     cur_op;
   logic signed [COF_W-1:0]    mul_a;
   logic signed [COF_W-1:0]    mul_b;
   dlt_tri_pkg::mac_ctl_type   ctl;
   logic                       mac_start;
   logic signed [SUM_W-1:0]    mac_sum;
   logic                       mac_done;
   logic [SUM_W-1:0]           num_sel;
   logic [SUM_W-1:0]           num_mag;
   logic [SUM_W-1:0]           det_mag;
   logic [REM_W-1:0]           rem_sh;
   logic [REM_W:0]             diff;
   logic                       pos_ovf;
   logic                       neg_ovf;
   logic [WORD_BITS-1:0]       q_word;

   function automatic op_type op_entry(input logic [4:0] op);
      op_type e;
      e = '{src_a: S_N0, src_b: S_N0, clear: 1'b1};
      unique case (op)
         5'd0:    e = '{S_N3, S_N5, 1'b1};
         5'd1:    e = '{S_N4, S_N4, 1'b0};
         5'd2:    e = '{S_N2, S_N4, 1'b1};
         5'd3:    e = '{S_N1, S_N5, 1'b0};
         5'd4:    e = '{S_N1, S_N4, 1'b1};
         5'd5:    e = '{S_N2, S_N3, 1'b0};
         5'd6:    e = '{S_N0, S_N5, 1'b1};
         5'd7:    e = '{S_N2, S_N2, 1'b0};
         5'd8:    e = '{S_N1, S_N2, 1'b1};
         5'd9:    e = '{S_N0, S_N4, 1'b0};
         5'd10:   e = '{S_N0, S_N3, 1'b1};
         5'd11:   e = '{S_N1, S_N1, 1'b0};
         5'd12:   e = '{S_N0, S_C0, 1'b1};
         5'd13:   e = '{S_N1, S_C1, 1'b0};
         5'd14:   e = '{S_N2, S_C2, 1'b0};
         5'd15:   e = '{S_C0, S_R0, 1'b1};
         5'd16:   e = '{S_C1, S_R1, 1'b0};
         5'd17:   e = '{S_C2, S_R2, 1'b0};
         5'd18:   e = '{S_C1, S_R0, 1'b1};
         5'd19:   e = '{S_C3, S_R1, 1'b0};
         5'd20:   e = '{S_C4, S_R2, 1'b0};
         5'd21:   e = '{S_C2, S_R0, 1'b1};
         5'd22:   e = '{S_C4, S_R1, 1'b0};
         5'd23:   e = '{S_C5, S_R2, 1'b0};
         default: e = '{S_N0, S_N0, 1'b1};
      endcase
      return e;
   endfunction

   function automatic logic signed [COF_W-1:0] src_val(input src_type s);
      logic signed [COF_W-1:0] v;
      v = '0;
      unique case (s)
         S_N0:    v = COF_W'($signed(n_ff[0]));
         S_N1:    v = COF_W'($signed(n_ff[1]));
         S_N2:    v = COF_W'($signed(n_ff[2]));
         S_N3:    v = COF_W'($signed(n_ff[3]));
         S_N4:    v = COF_W'($signed(n_ff[4]));
         S_N5:    v = COF_W'($signed(n_ff[5]));
         S_R0:    v = COF_W'($signed(r_ff[0]));
         S_R1:    v = COF_W'($signed(r_ff[1]));
         S_R2:    v = COF_W'($signed(r_ff[2]));
         S_C0:    v = cof_ff[0];
         S_C1:    v = cof_ff[1];
         S_C2:    v = cof_ff[2];
         S_C3:    v = cof_ff[3];
         S_C4:    v = cof_ff[4];
         S_C5:    v = cof_ff[5];
         default: v = '0;
      endcase
      return v;
   endfunction

   assign cur_op       = op_entry(op_ff);
   assign mul_a        = src_val(cur_op.src_a);
   assign mul_b        = src_val(cur_op.src_b);
   assign ctl.clear    = cur_op.clear;
   assign ctl.subtract = (op_ff < 5'd12) && op_ff[0];
   assign mac_start    = (state_ff == ISSUE);

   dlt_tri_mac #(.OP_W(COF_W), .SUM_W(SUM_W)) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .ctl   (ctl),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .sum   (mac_sum),
      .done  (mac_done)
   );

   // Divider datapath
   assign num_sel = num_ff[idx_ff];
   assign num_mag = num_sel[SUM_W-1] ? (SUM_W'(0) - num_sel) : num_sel;
   assign det_mag = det_ff[SUM_W-1] ? (SUM_W'(0) - det_ff) : det_ff;
   assign rem_sh  = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
   assign diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign pos_ovf = |dvd_ff[DVD_W-1:WORD_BITS-1];
   assign neg_ovf = (|dvd_ff[DVD_W-1:WORD_BITS]) ||
                    (dvd_ff[WORD_BITS-1] && (|dvd_ff[WORD_BITS-2:0]));
   assign q_word  = dvd_ff[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  n_ff     <= acc.norm;
                  r_ff     <= acc.rhs;
                  op_ff    <= '0;
                  state_ff <= ISSUE;
               end
            end
            ISSUE: state_ff <= WAIT;
            WAIT: begin
               if (mac_done) begin
                  unique case (op_ff)
                     5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11:
                        cof_ff[op_ff[3:1]] <= COF_W'(mac_sum);
                     5'd14:   det_ff    <= mac_sum;
                     5'd17:   num_ff[0] <= mac_sum;
                     5'd20:   num_ff[1] <= mac_sum;
                     5'd23:   num_ff[2] <= mac_sum;
                     default: ;
                  endcase
                  if (op_ff == LAST_OP) begin
                     idx_ff <= '0;
                     if (det_ff == '0) begin
                        res_ff        <= '0;
                        degenerate_ff <= 1'b1;
                        state_ff      <= FINISH;
                     end else begin
                        degenerate_ff <= 1'b0;
                        state_ff      <= DIV_LOAD;
                     end
                  end else begin
                     op_ff    <= op_ff + 1'b1;
                     state_ff <= ISSUE;
                  end
               end
            end
            DIV_LOAD: begin
               dvd_ff   <= DVD_W'(num_mag) << FRAC_BITS;
               dvs_ff   <= det_mag;
               rem_ff   <= '0;
               qneg_ff  <= num_sel[SUM_W-1] ^ det_ff[SUM_W-1];
               cnt_ff   <= CNT_W'(DVD_W);
               state_ff <= DIV_STEP;
            end
            DIV_STEP: begin
               if (!diff[REM_W]) rem_ff <= diff[REM_W-1:0];
               else rem_ff <= rem_sh;
               dvd_ff <= {dvd_ff[DVD_W-2:0], ~diff[REM_W]};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) state_ff <= DIV_STORE;
            end
            DIV_STORE: begin
               if (!qneg_ff) begin
                  res_ff[idx_ff] <= pos_ovf ? {1'b0, {(WORD_BITS-1){1'b1}}} : q_word;
               end else begin
                  res_ff[idx_ff] <= neg_ovf ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                            : (WORD_BITS'(0) - q_word);
               end
               if (idx_ff == 2'd2) begin
                  state_ff <= FINISH;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= DIV_LOAD;
               end
            end
            FINISH: begin
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign world_x    = res_ff[0];
   assign world_y    = res_ff[1];
   assign world_z    = res_ff[2];
   assign degenerate = degenerate_ff;
   assign done       = done_ff;
endmodule

// ===== sv/dlt_point_triangulation.sv =====
// Rows 0 and 1 are stored; row 2 runs the two equation lanes, 17 multiply-accumulate
// steps each on one 32 x 32 multiplier. A last item adds 24 cofactor-solve steps on
// 129-bit operands and, unless the determinant is zero, three restoring divisions of
// SOLVE_SUM_W + FRAC_BITS quotient bits each.
// Throughput: one item at a time; a finished result may wait in the output register.
// Reset (synchronous, active high) clears row stores, accumulators and all control.
module dlt_point_triangulation #(
   parameter int WORD_BITS = dlt_tri_pkg::WORD_BITS_DEFAULT,
   parameter int FRAC_BITS = dlt_tri_pkg::FRAC_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   dlt_tri_req_if.sink   req_chan,
   dlt_tri_rsp_if.source rsp_chan
);
   localparam logic [1:0] ROW_FIRST  = 2'd0;
   localparam logic [1:0] ROW_SECOND = 2'd1;
   localparam logic [1:0] ROW_THIRD  = 2'd2;

   typedef enum logic [2:0] {
      IDLE, LANES, MERGE_X, MERGE_Y, SOLVE_GO, SOLVE_WAIT, EMIT
   } state_type;

   state_type                  state_ff;
   logic                       last_ff;
   logic [3:0][WORD_BITS-1:0]  first_row_ff;
   logic [3:0][WORD_BITS-1:0]  second_row_ff;
   logic [3:0][WORD_BITS-1:0]  p2_row;
   logic                       transfer_in;
   logic                       lane_start;
   logic                       lane_x_done;
   logic                       lane_y_done;
   dlt_tri_pkg::acc_set_type   lane_x_terms;
   dlt_tri_pkg::acc_set_type   lane_y_terms;
   dlt_tri_pkg::acc_set_type   merge_terms;
   dlt_tri_pkg::acc_set_type   acc;
   logic                       merge_add;
   logic                       acc_clear;
   logic                       solve_start;
   logic                       solve_done;
   logic [WORD_BITS-1:0]       solve_x;
   logic [WORD_BITS-1:0]       solve_y;
   logic [WORD_BITS-1:0]       solve_z;
   logic                       solve_degenerate;
   logic                       rsp_valid_ff;
   logic [WORD_BITS-1:0]       world_x_ff;
   logic [WORD_BITS-1:0]       world_y_ff;
   logic [WORD_BITS-1:0]       world_z_ff;
   logic                       degenerate_ff;
   logic                       emit_now;

   // Accept a transfer only when idle; the output register stays independent
   assign req_chan.ready = (state_ff == IDLE);
   assign transfer_in    = req_chan.valid && req_chan.ready;
   assign lane_start     = transfer_in && (req_chan.row_select == ROW_THIRD);
   assign p2_row         = {req_chan.coeff_3, req_chan.coeff_2,
                            req_chan.coeff_1, req_chan.coeff_0};

   // Merge the x equation first, then the y equation: saturation is order dependent
   assign merge_add   = (state_ff == MERGE_X) || (state_ff == MERGE_Y);
   assign merge_terms = (state_ff == MERGE_Y) ? lane_y_terms : lane_x_terms;

   // The solver latches the accumulators on the same edge that clears them
   assign solve_start = (state_ff == SOLVE_GO);
   assign acc_clear   = solve_start;

   // Load the output register once the previous result has gone
   assign emit_now = (state_ff == EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   dlt_tri_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .start   (lane_start),
      .top_row (first_row_ff),
      .p2_row  (p2_row),
      .image   (req_chan.image_x),
      .scale_w (req_chan.image_w),
      .terms   (lane_x_terms),
      .done    (lane_x_done)
   );

   dlt_tri_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .start   (lane_start),
      .top_row (second_row_ff),
      .p2_row  (p2_row),
      .image   (req_chan.image_y),
      .scale_w (req_chan.image_w),
      .terms   (lane_y_terms),
      .done    (lane_y_done)
   );

   dlt_tri_merge u_merge (
      .clock (clock),
      .reset (reset),
      .clear (acc_clear),
      .add   (merge_add),
      .terms (merge_terms),
      .acc   (acc)
   );

   dlt_tri_solve #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_solve (
      .clock      (clock),
      .reset      (reset),
      .start      (solve_start),
      .acc        (acc),
      .world_x    (solve_x),
      .world_y    (solve_y),
      .world_z    (solve_z),
      .degenerate (solve_degenerate),
      .done       (solve_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         last_ff       <= 1'b0;
         first_row_ff  <= '0;
         second_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit_now) begin
            rsp_valid_ff  <= 1'b1;
            world_x_ff    <= solve_x;
            world_y_ff    <= solve_y;
            world_z_ff    <= solve_z;
            degenerate_ff <= solve_degenerate;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (transfer_in) begin
                  last_ff <= req_chan.last_item;
                  if (req_chan.row_select == ROW_FIRST) first_row_ff <= p2_row;
                  if (req_chan.row_select == ROW_SECOND) second_row_ff <= p2_row;
                  // Row 2 runs the lanes; a last item on any other row solves at once
                  if (req_chan.row_select == ROW_THIRD) state_ff <= LANES;
                  else if (req_chan.last_item) state_ff <= SOLVE_GO;
               end
            end
            LANES: begin
               if (lane_x_done && lane_y_done) state_ff <= MERGE_X;
            end
            MERGE_X: state_ff <= MERGE_Y;
            MERGE_Y: state_ff <= last_ff ? SOLVE_GO : IDLE;
            SOLVE_GO: state_ff <= SOLVE_WAIT;
            SOLVE_WAIT: begin
               if (solve_done) state_ff <= EMIT;
            end
            EMIT: begin
               if (emit_now) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.world_x    = world_x_ff;
   assign rsp_chan.world_y    = world_y_ff;
   assign rsp_chan.world_z    = world_z_ff;
   assign rsp_chan.degenerate = degenerate_ff;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int WB = 32;
   localparam int FB = 16;
   localparam int RANDOM_ITEMS = 900;
   // Length of the receiver's one long hold-off
   localparam int HOLD_OFF_CYCLES = 6000;
   localparam int DRAIN_CYCLES = 3000;
   localparam int WATCHDOG_LIMIT = 40000;

   localparam logic [1:0] ROW_TOP  = 2'd0;
   localparam logic [1:0] ROW_MID  = 2'd1;
   localparam logic [1:0] ROW_PROJ = 2'd2;
   localparam logic [1:0] ROW_NONE = 2'd3;

   localparam logic signed [WB-1:0] Q_ONE  = 32'sh0001_0000;
   localparam logic signed [WB-1:0] W_MAX  = 32'sh7fff_ffff;
   localparam logic signed [WB-1:0] W_MIN  = 32'sh8000_0000;

   typedef logic signed [255:0] wide_type;

   typedef enum logic {CHECK_MODEL, CHECK_TYPED} check_kind_type;

   typedef struct {
      logic [1:0]           row;
      logic signed [WB-1:0] c0, c1, c2, c3;
      logic signed [WB-1:0] ix, iy, iw;
      logic                 last;
   } proj_row_type;

   typedef struct {
      logic signed [WB-1:0] x, y, z;
      logic                 degen;
   } point_type;

   typedef struct {
      proj_row_type   row;
      check_kind_type kind;
      point_type      point;
   } stim_entry_type;

   logic clock;
   logic reset;

   dlt_tri_req_if #(.WORD_BITS(WB)) req_chan ();
   dlt_tri_rsp_if #(.WORD_BITS(WB)) rsp_chan ();

   dlt_point_triangulation #(.WORD_BITS(WB), .FRAC_BITS(FB)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow state of the triangulator
   logic signed [WB-1:0] held_row0 [4];
   logic signed [WB-1:0] held_row1 [4];
   logic signed [63:0]   normal_sum [6];
   logic signed [63:0]   rhs_sum [3];

   point_type      pending_points [$];
   stim_entry_type directed_rows [$];
   int             error_count = 0;
   int             points_seen = 0;
   logic           req_xfer, rsp_xfer;

   localparam point_type DEGEN_POINT = '{x: '0, y: '0, z: '0, degen: 1'b1};

   // ---------------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Shadow arithmetic: exact wide values, floor shifts, saturation
   // ---------------------------------------------------------------------------------
   function automatic logic signed [63:0] clamp64(wide_type v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      wide_type           whi;
      wide_type           wlo;
      hi  = 64'sh7fff_ffff_ffff_ffff;
      lo  = 64'sh8000_0000_0000_0000;
      whi = hi;
      wlo = lo;
      if (v > whi) return hi;
      if (v < wlo) return lo;
      return v[63:0];
   endfunction

   function automatic logic signed [WB-1:0] clamp_word(wide_type v);
      wide_type whi;
      wide_type wlo;
      whi = W_MAX;
      wlo = W_MIN;
      if (v > whi) return W_MAX;
      if (v < wlo) return W_MIN;
      return v[WB-1:0];
   endfunction

   // Fold one DLT equation (image coord against one held row) into the sums
   function automatic void fold_equation(logic signed [WB-1:0] top [4],
                                         wide_type p2 [4], wide_type img, wide_type w);
      wide_type           a [3];
      wide_type           b;
      wide_type           t;
      wide_type           acc;
      wide_type           tw;
      logic signed [63:0] s;
      int                 jr [6];
      int                 kr [6];
      jr = '{0, 0, 0, 1, 1, 2};
      kr = '{0, 1, 2, 1, 2, 2};
      for (int i = 0; i < 3; i++) begin
         tw   = top[i];
         s    = clamp64((img * p2[i] - w * tw) >>> FB);
         a[i] = s;
      end
      tw = top[3];
      s  = clamp64((w * tw - img * p2[3]) >>> FB);
      b  = s;
      for (int i = 0; i < 6; i++) begin
         s   = clamp64((a[jr[i]] * a[kr[i]]) >>> FB);
         t   = s;
         acc = normal_sum[i];
         normal_sum[i] = clamp64(acc + t);
      end
      for (int i = 0; i < 3; i++) begin
         s   = clamp64((a[i] * b) >>> FB);
         t   = s;
         acc = rhs_sum[i];
         rhs_sum[i] = clamp64(acc + t);
      end
   endfunction

   // Cramer's rule on the symmetric normal matrix
   function automatic point_type solve_point();
      wide_type  a, b, c, d, e, f;
      wide_type  r [3];
      wide_type  c00, c01, c02, c11, c12, c22, det;
      wide_type  num [3];
      point_type p;
      a = normal_sum[0]; b = normal_sum[1]; c = normal_sum[2];
      d = normal_sum[3]; e = normal_sum[4]; f = normal_sum[5];
      for (int i = 0; i < 3; i++) r[i] = rhs_sum[i];
      c00 = d * f - e * e;
      c01 = c * e - b * f;
      c02 = b * e - c * d;
      c11 = a * f - c * c;
      c12 = b * c - a * e;
      c22 = a * d - b * b;
      det = a * c00 + b * c01 + c * c02;
      if (det == 0) return DEGEN_POINT;
      num[0] = c00 * r[0] + c01 * r[1] + c02 * r[2];
      num[1] = c01 * r[0] + c11 * r[1] + c12 * r[2];
      num[2] = c02 * r[0] + c12 * r[1] + c22 * r[2];
      // Signed division truncates toward zero
      p.x     = clamp_word((num[0] <<< FB) / det);
      p.y     = clamp_word((num[1] <<< FB) / det);
      p.z     = clamp_word((num[2] <<< FB) / det);
      p.degen = 1'b0;
      return p;
   endfunction

   // Advance the shadow state by one accepted row; returns 1 when a point is due
   function automatic bit triangulate_row(proj_row_type it, output point_type p);
      wide_type p2 [4];
      case (it.row)
         ROW_TOP: begin
            held_row0 = '{it.c0, it.c1, it.c2, it.c3};
         end
         ROW_MID: begin
            held_row1 = '{it.c0, it.c1, it.c2, it.c3};
         end
         ROW_PROJ: begin
            p2[0] = it.c0; p2[1] = it.c1; p2[2] = it.c2; p2[3] = it.c3;
            fold_equation(held_row0, p2, wide_type'(it.ix), wide_type'(it.iw));
            fold_equation(held_row1, p2, wide_type'(it.iy), wide_type'(it.iw));
         end
         default: ;
      endcase
      p = DEGEN_POINT;
      if (!it.last) return 1'b0;
      p = solve_point();
      foreach (normal_sum[i]) normal_sum[i] = '0;
      foreach (rhs_sum[i]) rhs_sum[i] = '0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender: offer one row, hold it until the transfer, then record the expectation
   // ---------------------------------------------------------------------------------
   int burst_left = 0;

   task automatic offer_row(proj_row_type it, check_kind_type kind, point_type typed_point);
      point_type p;
      bit        due;
      // Between bursts: usually drop valid for a gap, sometimes start a long burst at once
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(100, 300);
         end else begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.row_select <= it.row;
      req_chan.coeff_0    <= it.c0;
      req_chan.coeff_1    <= it.c1;
      req_chan.coeff_2    <= it.c2;
      req_chan.coeff_3    <= it.c3;
      req_chan.image_x    <= it.ix;
      req_chan.image_y    <= it.iy;
      req_chan.image_w    <= it.iw;
      req_chan.last_item  <= it.last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      due = triangulate_row(it, p);
      if (due) begin
         if (kind == CHECK_TYPED) pending_points.push_back(typed_point);
         else pending_points.push_back(p);
      end
   endtask

   function automatic proj_row_type make_row(logic [1:0] row,
                                             logic signed [WB-1:0] c0, c1, c2, c3,
                                             logic signed [WB-1:0] ix, iy, iw,
                                             logic last);
      proj_row_type it;
      it = '{row: row, c0: c0, c1: c1, c2: c2, c3: c3, ix: ix, iy: iy, iw: iw,
             last: last};
      return it;
   endfunction

   function automatic void add_directed(proj_row_type it, check_kind_type kind);
      stim_entry_type e;
      e.row   = it;
      e.kind  = kind;
      e.point = DEGEN_POINT;
      directed_rows.push_back(e);
   endfunction

   // Word generator: style 0 moderate, 1 full range, 2 extremes mixed in
   function automatic logic signed [WB-1:0] pick_word(int style);
      logic signed [WB-1:0] v;
      int                   k;
      k = $urandom_range(0, 4);
      if (style == 2 && $urandom_range(0, 2) == 0) begin
         case (k)
            0: v = W_MAX;
            1: v = W_MIN;
            2: v = '0;
            3: v = -1;
            default: v = Q_ONE;
         endcase
      end else if (style == 0) begin
         v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   function automatic proj_row_type random_row(logic [1:0] row, logic last, int style);
      return make_row(row, pick_word(style), pick_word(style), pick_word(style),
                      pick_word(style), pick_word(style), pick_word(style),
                      pick_word(style), last);
   endfunction

   // ---------------------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------------------
   initial begin
      // Nothing accumulated after reset: the solve is degenerate
      add_directed(make_row(ROW_TOP, Q_ONE, 0, 0, 0, W_MAX, W_MIN, -1, 1'b1), CHECK_TYPED);
      // Unused row select stores nothing and still solves on an empty system
      add_directed(make_row(ROW_NONE, -1, -1, -1, -1, -1, -1, -1, 1'b1), CHECK_TYPED);
      // Last flag on row 1 with no row 2 folded in yet
      add_directed(make_row(ROW_TOP, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b0), CHECK_TYPED);
      add_directed(make_row(ROW_MID, 0, Q_ONE, 0, 0, 0, 0, 0, 1'b1), CHECK_TYPED);
      // Two well-placed cameras looking at (1, 2, 4)
      add_directed(make_row(ROW_TOP, Q_ONE, 0, 0, 0, W_MIN, W_MAX, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_MID, 0, Q_ONE, 0, 0, 0, 0, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_PROJ, 0, 0, Q_ONE, 0, 32'sh0000_4000, 32'sh0000_8000,
                            Q_ONE, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_TOP, Q_ONE, 0, 0, -Q_ONE, 0, 0, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_MID, 0, Q_ONE, 0, Q_ONE, 0, 0, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_PROJ, 0, 0, Q_ONE, Q_ONE, 0, 32'sh0000_9999, Q_ONE, 1'b1),
                   CHECK_MODEL);
      // Row 2 with only the held rows of the previous camera
      add_directed(make_row(ROW_PROJ, Q_ONE, Q_ONE, Q_ONE, 0, Q_ONE, -Q_ONE, Q_ONE, 1'b0),
                   CHECK_MODEL);
      add_directed(make_row(ROW_PROJ, 0, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1),
                   CHECK_MODEL);
      // Extreme coefficient and image words
      add_directed(make_row(ROW_TOP, W_MAX, W_MIN, W_MAX, W_MIN, 0, 0, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_MID, W_MIN, W_MAX, W_MIN, W_MAX, 0, 0, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_PROJ, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, 1'b0),
                   CHECK_MODEL);
      add_directed(make_row(ROW_PROJ, W_MIN, W_MAX, W_MAX, -1, W_MAX, W_MIN, W_MIN, 1'b1),
                   CHECK_MODEL);
      // All-ones and all-zero words
      add_directed(make_row(ROW_TOP, -1, -1, -1, -1, -1, -1, -1, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_MID, 0, 0, 0, 0, 0, 0, 0, 1'b0), CHECK_MODEL);
      add_directed(make_row(ROW_PROJ, -1, 0, -1, 0, -1, -1, -1, 1'b1), CHECK_MODEL);
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int sent;
      int cams;
      int style;
      reset = 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.row_select <= ROW_TOP;
      req_chan.coeff_0    <= '0;
      req_chan.coeff_1    <= '0;
      req_chan.coeff_2    <= '0;
      req_chan.coeff_3    <= '0;
      req_chan.image_x    <= '0;
      req_chan.image_y    <= '0;
      req_chan.image_w    <= '0;
      req_chan.last_item  <= 1'b0;
      foreach (held_row0[i]) held_row0[i] = '0;
      foreach (held_row1[i]) held_row1[i] = '0;
      foreach (normal_sum[i]) normal_sum[i] = '0;
      foreach (rhs_sum[i]) rhs_sum[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i])
         offer_row(directed_rows[i].row, directed_rows[i].kind, directed_rows[i].point);

      // Mostly whole points from several cameras, the rest loose or broken rows
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            cams  = $urandom_range(2, 4);
            style = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
            for (int cam = 0; cam < cams; cam++) begin
               offer_row(random_row(ROW_TOP, 1'b0, style), CHECK_MODEL, DEGEN_POINT);
               offer_row(random_row(ROW_MID, 1'b0, style), CHECK_MODEL, DEGEN_POINT);
               offer_row(random_row(ROW_PROJ, cam == cams - 1, style), CHECK_MODEL,
                         DEGEN_POINT);
               sent += 3;
            end
         end else begin
            offer_row(random_row(2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                                 $urandom_range(0, 2)), CHECK_MODEL, DEGEN_POINT);
            sent++;
         end
      end
      req_chan.valid <= 1'b0;

      // Drain, then allow for a stray late result
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off to back the block up
   // ---------------------------------------------------------------------------------
   initial begin
      int  mode;
      bit  held;
      held = 1'b0;
      mode = 0;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!held && points_seen >= 8) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= $urandom_range(0, 1);
            default: rsp_chan.ready <= $urandom_range(0, 3) == 0;
         endcase
         @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------------
   // Result checker: compare each transfer with the oldest expected point
   // ---------------------------------------------------------------------------------
   assign req_xfer = req_chan.valid === 1'b1 && req_chan.ready === 1'b1;
   assign rsp_xfer = rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1;

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_xfer) begin
         points_seen <= points_seen + 1;
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point x=%h y=%h z=%h degenerate=%b", $time,
                     rsp_chan.world_x, rsp_chan.world_y, rsp_chan.world_z,
                     rsp_chan.degenerate);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_chan.world_x !== want.x) begin
               $display("%0t: world_x expected %h actual %h", $time, want.x,
                        rsp_chan.world_x);
               error_count++;
            end
            if (rsp_chan.world_y !== want.y) begin
               $display("%0t: world_y expected %h actual %h", $time, want.y,
                        rsp_chan.world_y);
               error_count++;
            end
            if (rsp_chan.world_z !== want.z) begin
               $display("%0t: world_z expected %h actual %h", $time, want.z,
                        rsp_chan.world_z);
               error_count++;
            end
            if (rsp_chan.degenerate !== want.degen) begin
               $display("%0t: degenerate expected %b actual %b", $time, want.degen,
                        rsp_chan.degenerate);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: count cycles without any transfer
   // ---------------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (req_xfer || rsp_xfer) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== dlt_point_triangulation.f =====
sv/dlt_tri_pkg.sv
sv/dlt_tri_req_if.sv
sv/dlt_tri_rsp_if.sv
sv/dlt_tri_mac.sv
sv/dlt_tri_lane.sv
sv/dlt_tri_merge.sv
sv/dlt_tri_solve.sv
sv/dlt_point_triangulation.sv
tb/tb.sv
